// ----- rtl/hkre_pkg.sv -----
// hkre_pkg: shared types, constants and helpers for the keyboard report event unit
// used by hkre_front, hkre_queue, hkre_back and the top level; no dependencies
package hkre_pkg;

    localparam int KEY_SLOTS  = 6;
    localparam int NUM_EV     = 2 * KEY_SLOTS + 3;
    localparam int EV_CTRL    = 2 * KEY_SLOTS;
    localparam int EV_SHIFT   = 2 * KEY_SLOTS + 1;
    localparam int EV_ALT     = 2 * KEY_SLOTS + 2;
    localparam int QDEPTH     = 2;
    localparam int Q_PTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(QDEPTH + 1);

    localparam logic [3:0] RPT_KEYBOARD = 4'h4;

    localparam logic [7:0] MOD_CTRL_MASK  = 8'h11;
    localparam logic [7:0] MOD_SHIFT_MASK = 8'h22;
    localparam logic [7:0] MOD_ALT_MASK   = 8'h44;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_CTRL  = 2'd1,
        KIND_SHIFT = 2'd2,
        KIND_ALT   = 2'd3
    } kind_t;

    typedef logic [KEY_SLOTS-1:0][7:0] slots_t;

    // one classified report: codes of both reports, pending events, modifier levels
    typedef struct packed {
        slots_t              old_codes;
        slots_t              new_codes;
        logic [NUM_EV-1:0]   ev_mask;
        logic [2:0]          mod_press;
    } job_t;

    function automatic logic code_mapped(input logic [7:0] c);
        code_mapped = ((c >= 8'h04) && (c <= 8'h31)) ||
                      ((c >= 8'h33) && (c <= 8'h38)) ||
                      ((c >= 8'h3A) && (c <= 8'h45)) ||
                      ((c >= 8'h48) && (c <= 8'h52));
    endfunction

endpackage

// ----- rtl/hkre_front.sv -----
// hkre_front: accepts reports, diffs them against the stored report, builds a job
// depends on hkre_pkg
module hkre_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [3:0]           report_type,
    input  logic [7:0]           modifier_bits,
    input  hkre_pkg::slots_t     key_slots,
    input  logic                 q_full,
    output logic                 push,
    output hkre_pkg::job_t       push_job
);

    hkre_pkg::slots_t                  prev_slots_reg;
    hkre_pkg::slots_t                  prev_slots_next;
    logic [7:0]                        prev_mods_reg;
    logic [7:0]                        prev_mods_next;
    logic [hkre_pkg::KEY_SLOTS-1:0]    old_hit;
    logic [hkre_pkg::KEY_SLOTS-1:0]    new_hit;
    logic [hkre_pkg::NUM_EV-1:0]       mask;
    logic [7:0]                        diff;
    logic                              take;
    logic                              is_kbd;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;
    assign is_kbd   = (report_type == hkre_pkg::RPT_KEYBOARD);
    assign diff     = modifier_bits ^ prev_mods_reg;

    always_comb
    begin
        old_hit = '0;
        new_hit = '0;
        for (int i = 0; i < hkre_pkg::KEY_SLOTS; i++)
        begin
            for (int j = 0; j < hkre_pkg::KEY_SLOTS; j++)
            begin
                if (key_slots[j] == prev_slots_reg[i])
                begin
                    old_hit[i] = 1'b1;
                end
                if (prev_slots_reg[j] == key_slots[i])
                begin
                    new_hit[i] = 1'b1;
                end
            end
        end
        mask = '0;
        for (int i = 0; i < hkre_pkg::KEY_SLOTS; i++)
        begin
            mask[i] = (prev_slots_reg[i] != 8'h00) && !old_hit[i] &&
                      hkre_pkg::code_mapped(prev_slots_reg[i]);
            mask[hkre_pkg::KEY_SLOTS + i] = (key_slots[i] != 8'h00) && !new_hit[i] &&
                      hkre_pkg::code_mapped(key_slots[i]);
        end
        mask[hkre_pkg::EV_CTRL]  = |(diff & hkre_pkg::MOD_CTRL_MASK);
        mask[hkre_pkg::EV_SHIFT] = |(diff & hkre_pkg::MOD_SHIFT_MASK);
        mask[hkre_pkg::EV_ALT]   = |(diff & hkre_pkg::MOD_ALT_MASK);
    end

    assign push_job.old_codes    = prev_slots_reg;
    assign push_job.new_codes    = key_slots;
    assign push_job.ev_mask      = mask;
    assign push_job.mod_press[0] = |(modifier_bits & hkre_pkg::MOD_CTRL_MASK);
    assign push_job.mod_press[1] = |(modifier_bits & hkre_pkg::MOD_SHIFT_MASK);
    assign push_job.mod_press[2] = |(modifier_bits & hkre_pkg::MOD_ALT_MASK);

    // keyboard reports with nothing to say update the state but enqueue nothing
    assign push = take && is_kbd && (|mask);

    always_comb
    begin
        prev_slots_next = prev_slots_reg;
        prev_mods_next  = prev_mods_reg;
        if (take && is_kbd)
        begin
            prev_slots_next = key_slots;
            prev_mods_next  = modifier_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_slots_reg <= '0;
            prev_mods_reg  <= '0;
        end
        else
        begin
            prev_slots_reg <= prev_slots_next;
            prev_mods_reg  <= prev_mods_next;
        end
    end

endmodule

// ----- rtl/hkre_queue.sv -----
// hkre_queue: short job queue between the classifier and the event sequencer
// depends on hkre_pkg
module hkre_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hkre_pkg::job_t    push_job,
    output logic              full,
    output logic              q_valid,
    output hkre_pkg::job_t    q_job,
    input  logic              pop
);

    hkre_pkg::job_t                 mem_reg [hkre_pkg::QDEPTH];
    logic [hkre_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [hkre_pkg::Q_PTR_W-1:0]   wr_ptr_next;
    logic [hkre_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [hkre_pkg::Q_PTR_W-1:0]   rd_ptr_next;
    logic [hkre_pkg::Q_CNT_W-1:0]   count_reg;
    logic [hkre_pkg::Q_CNT_W-1:0]   count_next;

    localparam logic [hkre_pkg::Q_CNT_W-1:0] CNT_FULL = hkre_pkg::Q_CNT_W'(hkre_pkg::QDEPTH);
    localparam logic [hkre_pkg::Q_PTR_W-1:0] PTR_LAST =
        hkre_pkg::Q_PTR_W'(hkre_pkg::QDEPTH - 1);

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("hkre_queue: push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("hkre_queue: pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("hkre_queue: count out of range");

endmodule

// ----- rtl/hkre_back.sv -----
// hkre_back: walks the head job's pending events into the output register, one per cycle
// while out_stall does not hold it; depends on hkre_pkg
module hkre_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  hkre_pkg::job_t    q_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        scan_code,
    output logic [1:0]        modifier_kind,
    output logic              is_press,
    output logic              last_event
);

    logic                          active_reg;
    logic                          active_next;
    logic [hkre_pkg::NUM_EV-1:0]   pend_reg;
    logic [hkre_pkg::NUM_EV-1:0]   pend_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [7:0]                    scan_reg;
    logic [7:0]                    scan_next;
    hkre_pkg::kind_t               kind_reg;
    hkre_pkg::kind_t               kind_next;
    logic                          press_reg;
    logic                          press_next;
    logic                          last_reg;
    logic                          last_next;
    logic [hkre_pkg::NUM_EV-1:0]   rem;
    logic [hkre_pkg::NUM_EV-1:0]   pick;
    logic [hkre_pkg::NUM_EV-1:0]   rem_after;
    logic [7:0]                    sel_code;
    logic                          load;

    assign rem       = active_reg ? pend_reg : q_job.ev_mask;
    // lowest pending event goes first
    assign pick      = rem & (~rem + 1'b1);
    assign rem_after = rem & ~pick;
    assign load      = q_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && (rem_after == '0);

    always_comb
    begin
        sel_code = '0;
        for (int i = 0; i < hkre_pkg::KEY_SLOTS; i++)
        begin
            sel_code = sel_code
                     | (q_job.old_codes[i] & {8{pick[i]}})
                     | (q_job.new_codes[i] & {8{pick[hkre_pkg::KEY_SLOTS + i]}});
        end
    end

    always_comb
    begin
        active_next    = active_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        scan_next      = scan_reg;
        kind_next      = kind_reg;
        press_next     = press_reg;
        last_next      = last_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            scan_next      = sel_code;
            last_next      = (rem_after == '0);
            active_next    = (rem_after != '0);
            pend_next      = rem_after;
            if (pick[hkre_pkg::EV_CTRL])
            begin
                kind_next  = hkre_pkg::KIND_CTRL;
                press_next = q_job.mod_press[0];
            end
            else if (pick[hkre_pkg::EV_SHIFT])
            begin
                kind_next  = hkre_pkg::KIND_SHIFT;
                press_next = q_job.mod_press[1];
            end
            else if (pick[hkre_pkg::EV_ALT])
            begin
                kind_next  = hkre_pkg::KIND_ALT;
                press_next = q_job.mod_press[2];
            end
            else
            begin
                kind_next  = hkre_pkg::KIND_KEY;
                press_next = |pick[2*hkre_pkg::KEY_SLOTS-1:hkre_pkg::KEY_SLOTS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg  <= pend_next;
        scan_reg  <= scan_next;
        kind_reg  <= kind_next;
        press_reg <= press_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign scan_code     = scan_reg;
    assign modifier_kind = kind_reg;
    assign is_press      = press_reg;
    assign last_event    = last_reg;

    a_active_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> q_valid)
        else $error("hkre_back: walking a job with an empty queue");

    a_load_has_event: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> $onehot(pick))
        else $error("hkre_back: loaded with no pending event");

    a_modifier_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != hkre_pkg::KIND_KEY)) |-> (scan_reg == 8'h00))
        else $error("hkre_back: modifier event carries a scancode");

    a_pop_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && last_reg && !active_reg))
        else $error("hkre_back: job retired without a final event");

endmodule

// ----- rtl/hid_keyboard_report_to_key_events_unit.sv -----
// hid_keyboard_report_to_key_events_unit: keyboard report to key event stream, top level
// depends on hkre_pkg, hkre_front, hkre_queue, hkre_back
//
//   channel  signals                                         direction
//   in       in_valid, in_stall, report_type, modifier_bits,  report in
//            key_slot_0 .. key_slot_5
//   out      out_valid, out_stall, scan_code, modifier_kind,  event out
//            is_press, last_event
//
// a report is classified in the cycle of its transfer; the sequencer then sends
// one event per cycle unless out_stall holds it; a queued report yields 1 to 15 events
// a two-entry job queue sits between classifier and sequencer; in_stall is high
// only while it is full, and reports with no events never enter it
// out_stall holds the output register and the sequencer; it reaches the input side
// only once the queue has filled up
// reset clears the stored report, modifiers, queue and output valid
module hid_keyboard_report_to_key_events_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  report_type,
    input  logic [7:0]  modifier_bits,
    input  logic [7:0]  key_slot_0,
    input  logic [7:0]  key_slot_1,
    input  logic [7:0]  key_slot_2,
    input  logic [7:0]  key_slot_3,
    input  logic [7:0]  key_slot_4,
    input  logic [7:0]  key_slot_5,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  scan_code,
    output logic [1:0]  modifier_kind,
    output logic        is_press,
    output logic        last_event
);

    hkre_pkg::slots_t  key_slots;
    hkre_pkg::job_t    push_job;
    hkre_pkg::job_t    q_job;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;

    assign key_slots = {key_slot_5, key_slot_4, key_slot_3,
                        key_slot_2, key_slot_1, key_slot_0};

    hkre_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .report_type   (report_type),
        .modifier_bits (modifier_bits),
        .key_slots     (key_slots),
        .q_full        (q_full),
        .push          (push),
        .push_job      (push_job)
    );

    hkre_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop)
    );

    hkre_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (q_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scan_code     (scan_code),
        .modifier_kind (modifier_kind),
        .is_press      (is_press),
        .last_event    (last_event)
    );

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking testbench for hid_keyboard_report_to_key_events_unit
// depends on hkre_pkg and the unit's RTL; a directed table is followed by random reports

module tb_top;

    typedef struct packed {
        logic [3:0]       rtype;
        logic [7:0]       mods;
        hkre_pkg::slots_t slots;
    } key_report_t;

    typedef struct packed {
        logic [7:0]      scan;
        hkre_pkg::kind_t kind;
        logic            press;
        logic            last;
    } key_event_t;

    typedef enum {CHECK_PREDICTED, CHECK_NO_EVENT, CHECK_ONE_EVENT} row_check_t;

    typedef struct {
        key_report_t rpt;
        row_check_t  check;
        key_event_t  ev;
    } stim_row_t;

    localparam key_event_t NO_EVENT = '0;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [3:0] report_type;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] scan_code;
    logic [1:0] modifier_kind;
    logic       is_press;
    logic       last_event;

    // last stored keyboard report, as the unit should hold it
    hkre_pkg::slots_t held_slots = '0;
    logic [7:0]       held_mods  = 8'h00;

    key_event_t pending_events[$];
    stim_row_t  rows[$];
    bit         calm;
    int         errors;
    int         reports_sent;
    int         keyboard_reports;
    int         events_checked;
    int         most_events;
    int         kb_random;

    hid_keyboard_report_to_key_events_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .report_type   (report_type),
        .modifier_bits (modifier_bits),
        .key_slot_0    (key_slot_0),
        .key_slot_1    (key_slot_1),
        .key_slot_2    (key_slot_2),
        .key_slot_3    (key_slot_3),
        .key_slot_4    (key_slot_4),
        .key_slot_5    (key_slot_5),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scan_code     (scan_code),
        .modifier_kind (modifier_kind),
        .is_press      (is_press),
        .last_event    (last_event)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic bit is_mapped_code(input logic [7:0] c);
        return (c >= 8'h04 && c <= 8'h31) || (c >= 8'h33 && c <= 8'h38) ||
               (c >= 8'h3A && c <= 8'h45) || (c >= 8'h48 && c <= 8'h52);
    endfunction

    function automatic bit slots_contain(input hkre_pkg::slots_t s, input logic [7:0] c);
        int i;
        for (i = 0; i < hkre_pkg::KEY_SLOTS; i++)
            if (s[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic key_event_t key_ev(input logic [7:0] scan, input hkre_pkg::kind_t kind,
                                          input logic press);
        key_event_t e;
        e.scan  = scan;
        e.kind  = kind;
        e.press = press;
        e.last  = 1'b1;
        return e;
    endfunction

    // releases, then presses, then modifier edges; the report is stored afterwards
    function automatic void predict_key_events(input key_report_t r, output key_event_t evs[$]);
        logic [7:0] changed;
        int         i;
        evs = {};
        if (r.rtype != hkre_pkg::RPT_KEYBOARD)
            return;
        for (i = 0; i < hkre_pkg::KEY_SLOTS; i++)
            if (held_slots[i] != 8'h00 && !slots_contain(r.slots, held_slots[i]) &&
                is_mapped_code(held_slots[i]))
                evs.push_back(key_ev(held_slots[i], hkre_pkg::KIND_KEY, 1'b0));
        for (i = 0; i < hkre_pkg::KEY_SLOTS; i++)
            if (r.slots[i] != 8'h00 && !slots_contain(held_slots, r.slots[i]) &&
                is_mapped_code(r.slots[i]))
                evs.push_back(key_ev(r.slots[i], hkre_pkg::KIND_KEY, 1'b1));
        changed = r.mods ^ held_mods;
        if ((changed & hkre_pkg::MOD_CTRL_MASK) != 8'h00)
            evs.push_back(key_ev(8'h00, hkre_pkg::KIND_CTRL,
                                 (r.mods & hkre_pkg::MOD_CTRL_MASK) != 8'h00));
        if ((changed & hkre_pkg::MOD_SHIFT_MASK) != 8'h00)
            evs.push_back(key_ev(8'h00, hkre_pkg::KIND_SHIFT,
                                 (r.mods & hkre_pkg::MOD_SHIFT_MASK) != 8'h00));
        if ((changed & hkre_pkg::MOD_ALT_MASK) != 8'h00)
            evs.push_back(key_ev(8'h00, hkre_pkg::KIND_ALT,
                                 (r.mods & hkre_pkg::MOD_ALT_MASK) != 8'h00));
        held_slots = r.slots;
        held_mods  = r.mods;
        for (i = 0; i < evs.size(); i++)
            evs[i].last = (i == evs.size() - 1);
    endfunction

    task automatic add_row(input logic [3:0] rtype, input logic [7:0] mods,
                           input logic [7:0] s [hkre_pkg::KEY_SLOTS], input row_check_t check,
                           input key_event_t ev);
        stim_row_t row;
        int        i;
        row.rpt.rtype = rtype;
        row.rpt.mods  = mods;
        for (i = 0; i < hkre_pkg::KEY_SLOTS; i++)
            row.rpt.slots[i] = s[i];
        row.check = check;
        row.ev    = ev;
        rows.push_back(row);
    endtask

    // mostly keyboard reports that evolve from the last one, some noise
    function automatic key_report_t make_random_report();
        key_report_t r;
        int          pick;
        int          i;
        bit          burst;
        r.rtype = ($urandom_range(99) < 12) ? 4'($urandom_range(15)) : hkre_pkg::RPT_KEYBOARD;
        burst   = ($urandom_range(99) < 8);
        pick    = $urandom_range(99);
        if (burst)
            r.mods = ~held_mods;
        else if (pick < 45)
            r.mods = held_mods;
        else if (pick < 75)
            r.mods = held_mods ^ (8'h01 << $urandom_range(7));
        else
            r.mods = 8'($urandom);
        for (i = 0; i < hkre_pkg::KEY_SLOTS; i++)
        begin
            pick = burst ? 70 : $urandom_range(99);
            if (pick < 40)
                r.slots[i] = held_slots[$urandom_range(hkre_pkg::KEY_SLOTS - 1)];
            else if (pick < 60)
                r.slots[i] = 8'h00;
            else if (pick < 90)
                r.slots[i] = 8'($urandom_range(8'h52, 8'h04));
            else
                r.slots[i] = 8'($urandom);
        end
        return r;
    endfunction

    task automatic send_report(input key_report_t r, input row_check_t check,
                               input key_event_t typed);
        key_event_t evs[$];
        while (!calm && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        report_type   <= r.rtype;
        modifier_bits <= r.mods;
        key_slot_0    <= r.slots[0];
        key_slot_1    <= r.slots[1];
        key_slot_2    <= r.slots[2];
        key_slot_3    <= r.slots[3];
        key_slot_4    <= r.slots[4];
        key_slot_5    <= r.slots[5];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_key_events(r, evs);
        case (check)
            CHECK_NO_EVENT:  evs = {};
            CHECK_ONE_EVENT: evs = {typed};
            default: ;
        endcase
        foreach (evs[k])
            pending_events.push_back(evs[k]);
        reports_sent++;
        if (r.rtype == hkre_pkg::RPT_KEYBOARD)
            keyboard_reports++;
        if (evs.size() > most_events)
            most_events = evs.size();
        @(negedge clk);
    endtask

    // receiver back-pressure
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !calm && ($urandom_range(99) < 29);
        end
    end

    always @(posedge clk)
    begin
        key_event_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: scan_code %h modifier_kind %0d is_press %b",
                       scan_code, modifier_kind, is_press);
                errors++;
            end
            else
            begin
                want = pending_events.pop_front();
                events_checked++;
                if (scan_code !== want.scan)
                begin
                    $error("scan_code: expected %h, got %h", want.scan, scan_code);
                    errors++;
                end
                if (modifier_kind !== want.kind)
                begin
                    $error("modifier_kind: expected %0d, got %0d", want.kind, modifier_kind);
                    errors++;
                end
                if (is_press !== want.press)
                begin
                    $error("is_press: expected %b, got %b", want.press, is_press);
                    errors++;
                end
                if (last_event !== want.last)
                begin
                    $error("last_event: expected %b, got %b", want.last, last_event);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        report_type   <= 4'h0;
        modifier_bits <= 8'h00;
        key_slot_0    <= 8'h00;
        key_slot_1    <= 8'h00;
        key_slot_2    <= 8'h00;
        key_slot_3    <= 8'h00;
        key_slot_4    <= 8'h00;
        key_slot_5    <= 8'h00;
        calm          = 1'b0;

        // single key after reset, then its release
        add_row(4'h4, 8'h00, '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_ONE_EVENT, key_ev(8'h04, hkre_pkg::KIND_KEY, 1'b1));
        add_row(4'h4, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_ONE_EVENT, key_ev(8'h04, hkre_pkg::KIND_KEY, 1'b0));
        // other device types are dropped
        add_row(4'h0, 8'hFF, '{8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A},
                CHECK_NO_EVENT, NO_EVENT);
        add_row(4'hF, 8'hFF, '{8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A},
                CHECK_NO_EVENT, NO_EVENT);
        // unmapped codes are stored but silent, both ways
        add_row(4'h4, 8'h00, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
                CHECK_NO_EVENT, NO_EVENT);
        add_row(4'h4, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_NO_EVENT, NO_EVENT);
        add_row(4'h4, 8'h01, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_ONE_EVENT, key_ev(8'h00, hkre_pkg::KIND_CTRL, 1'b1));
        // left to right ctrl swap still counts as a change
        add_row(4'h4, 8'h10, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'hFF, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'h88, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_PREDICTED, NO_EVENT);
        // bits 3 and 7 alone never cause events
        add_row(4'h4, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_NO_EVENT, NO_EVENT);
        add_row(4'h4, 8'h00, '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09},
                CHECK_PREDICTED, NO_EVENT);
        // duplicates and range edges
        add_row(4'h4, 8'h00, '{8'h04, 8'h04, 8'h31, 8'h33, 8'h38, 8'h3A},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'h00, '{8'h32, 8'h39, 8'h46, 8'h47, 8'h53, 8'h00},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'h00, '{8'h45, 8'h48, 8'h52, 8'h03, 8'h01, 8'h02},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'h00, '{8'h45, 8'h48, 8'h52, 8'h03, 8'h01, 8'h02},
                CHECK_NO_EVENT, NO_EVENT);
        // two disjoint full reports with all modifiers flipping: longest burst
        add_row(4'h4, 8'h00, '{8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'h77, '{8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'h80, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'h4, 8'h00, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE7},
                CHECK_NO_EVENT, NO_EVENT);
        add_row(4'h4, 8'h00, '{8'h80, 8'h7F, 8'hAA, 8'h55, 8'h01, 8'hFE},
                CHECK_PREDICTED, NO_EVENT);
        add_row(4'hB, 8'h5A, '{8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09},
                CHECK_NO_EVENT, NO_EVENT);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_report(rows[i].rpt, rows[i].check, rows[i].ev);

        while (kb_random < 70)
        begin
            key_report_t r;
            calm = (kb_random >= 20 && kb_random < 40);
            if (kb_random == 50)
            begin
                // let the unit drain completely before going on
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending_events.size() != 0)
                    @(negedge clk);
            end
            r = make_random_report();
            if (r.rtype == hkre_pkg::RPT_KEYBOARD)
                kb_random++;
            send_report(r, CHECK_PREDICTED, NO_EVENT);
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("run covered %0d reports (%0d keyboard) and %0d checked key/modifier events",
                 reports_sent, keyboard_reports, events_checked);
        $display("longest burst from one report: %0d events; mismatches: %0d",
                 most_events, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
